// ===== rtl/core/descriptor_slot_allocator_top_assert.svh =====
// Assertion macros shared by the descriptor slot allocator RTL.
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is held.
`define DSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Clocked check that also covers the reset cycles.
`define DSA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define DSA_ASSERT(lbl, prop, msg)
`define DSA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/dsa_pkg.sv =====
// Types, codes and constants of the descriptor slot allocator.
package dsa_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int MAX_PERSISTENT_DEF = 1024;
  localparam int MAX_TEMPORARY_DEF  = 1024;
  localparam int FRAMES_DEF         = 3;

  // Field widths fixed by the interface.
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 11;
  localparam int OFS_W      = 20;
  localparam int HEAP_W     = 2;
  localparam int OP_W       = 3;
  localparam int ST_W       = 3;
  localparam int DSZ_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int LIM_W      = CNT_W + 2;

  localparam logic [IDX_W-1:0] NO_SLOT = '1;

  // Request opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC_P   = 3'd0,
    OP_FREE_P    = 3'd1,
    OP_ALLOC_T   = 3'd2,
    OP_END_FRAME = 3'd3,
    OP_LOOKUP    = 3'd4
  } opcode_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_PFULL   = 3'd1,
    ST_TOVER   = 3'd2,
    ST_BADFREE = 3'd3,
    ST_BADLOOK = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERSISTENT = 2'd0,
    CFG_TEMPORARY  = 2'd1,
    CFG_DESC_SIZE  = 2'd2,
    CFG_SHADER_VIS = 2'd3
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // One request transaction.
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  slot_index;
    logic [CNT_W-1:0]  slot_count;
    logic [HEAP_W-1:0] frame_select;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [IDX_W-1:0]  result_index;
    logic [OFS_W-1:0]  byte_offset;
    logic [HEAP_W-1:0] heap_slot;
    logic [CNT_W-1:0]  in_use_count;
    logic [ST_W-1:0]   status;
  } out_item_t;

  // Write request into the free-index stack.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } stk_wr_t;

endpackage

// ===== rtl/core/dsa_stack.sv =====
// Free-index stack memory with a fill mark standing in for its identity reset.
`include "descriptor_slot_allocator_top_assert.svh"

module dsa_stack #(
  parameter int MAX_PERSISTENT = dsa_pkg::MAX_PERSISTENT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [dsa_pkg::IDX_W-1:0] rd_addr_i,
  output logic [dsa_pkg::IDX_W-1:0] rd_data_o,
  input  dsa_pkg::stk_wr_t        wr_i
);
  import dsa_pkg::*;

  localparam int AW = (MAX_PERSISTENT > 1) ? $clog2(MAX_PERSISTENT) : 1;
  localparam int MW = $clog2(MAX_PERSISTENT + 1);

  logic [AW-1:0]    mem [MAX_PERSISTENT];
  logic [AW-1:0]    rd_ram_r;
  logic             rd_hit_r;
  logic [IDX_W-1:0] rd_pos_r;
  logic [MW-1:0]    mark_r;
  logic [MW-1:0]    mark_nxt;
  logic [MW-1:0]    wr_end;
  logic             rd_below;

  // Every position from the allocation count up to the mark has been written;
  // positions at or above the mark still hold their own index.
  assign wr_end   = MW'(wr_i.addr) + MW'(1);
  assign rd_below = ({1'b0, rd_addr_i} < (IDX_W + 1)'(mark_r));

  always_comb begin
    mark_nxt = mark_r;
    if (wr_i.en && (wr_end > mark_r)) begin
      mark_nxt = wr_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= '0;
    end else begin
      mark_r <= mark_nxt;
    end
  end

  // Synchronous memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AW-1:0]] <= wr_i.data[AW-1:0];
    end
    rd_ram_r <= mem[rd_addr_i[AW-1:0]];
    rd_hit_r <= rd_below;
    rd_pos_r <= rd_addr_i;
  end

  assign rd_data_o = rd_hit_r ? IDX_W'(rd_ram_r) : rd_pos_r;

  `DSA_ASSERT(a_mark_range, mark_r <= MW'(MAX_PERSISTENT), "fill mark beyond stack depth")
  `DSA_ASSERT(a_mark_grows, 1'b1 |=> mark_r >= $past(mark_r), "fill mark moved down")
  `DSA_ASSERT(a_mark_covers, wr_i.en |=> mark_r >= $past(wr_end), "write above fill mark")

endmodule

// ===== rtl/core/descriptor_slot_allocator_top.sv =====
// Top level of the descriptor slot allocator: sequencer, counters and result register.
//
// Usage:
//   Requests enter on start/in_item and are taken when start is high and busy is
//   low. Every request gives exactly one result on out_item, shown for a single
//   cycle with out_strobe; the receiver has no way to hold it off.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is high whenever no request is in progress.
// Timing:
//   The cycle after acceptance reads the stack entry, which was fetched
//   from the synchronous memory at the accept edge, and updates the
//   counters; the result strobes in the cycle after that.
//   busy is high only in that execute cycle, so a new request can be
//   taken while the previous result is on the output. That execute
//   cycle is set by the registered read port of the free-index stack.
// Reset:
//   rst_n is synchronous, active low. It restores the control and config
//   registers to their defaults, empties the allocation counters and makes
//   the stack read as the identity at once (a fill mark replaces any clearing pass).
`include "descriptor_slot_allocator_top_assert.svh"

module descriptor_slot_allocator_top #(
  parameter int MAX_PERSISTENT = dsa_pkg::MAX_PERSISTENT_DEF,
  parameter int MAX_TEMPORARY  = dsa_pkg::MAX_TEMPORARY_DEF,
  parameter int FRAMES         = dsa_pkg::FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  dsa_pkg::in_item_t              in_item,
  output logic                           out_strobe,
  output dsa_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dsa_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0] cfg_pc_r;
  logic [CNT_W-1:0] cfg_tc_r;
  logic [DSZ_W-1:0] cfg_dsz_r;
  logic             cfg_sv_r;

  // Control and allocator state.
  state_t            state_r, state_nxt;
  in_item_t          item_r;
  logic [CNT_W-1:0]  alloc_r, alloc_nxt;
  logic [CNT_W-1:0]  temp_r, temp_nxt;
  logic [HEAP_W-1:0] heap_r, heap_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_strobe_r;

  // Working values.
  logic              accept;
  logic [CNT_W-1:0]  pc_eff;
  logic [CNT_W-1:0]  tc_eff;
  logic [2:0]        heap_cnt;
  logic [2:0]        heap_inc;
  logic [IDX_W-1:0]  t_sum;
  logic [IDX_W-1:0]  t_start;
  logic [IDX_W-1:0]  lk_lim;
  logic [IDX_W-1:0]  res;
  status_t           status;
  logic [IDX_W+DSZ_W-1:0] prod;
  logic [IDX_W-1:0]  stk_rd_data;
  stk_wr_t           stk_wr;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // Register limits clamped to the built capacity.
  assign pc_eff = (LIM_W'(cfg_pc_r) > LIM_W'(MAX_PERSISTENT)) ?
                  CNT_W'(MAX_PERSISTENT) : cfg_pc_r;
  assign tc_eff = (LIM_W'(cfg_tc_r) > LIM_W'(MAX_TEMPORARY)) ?
                  CNT_W'(MAX_TEMPORARY) : cfg_tc_r;
  assign heap_cnt = cfg_sv_r ? 3'(FRAMES) : 3'd1;

  assign heap_inc = {1'b0, heap_r} + 3'd1;
  assign t_sum    = {1'b0, temp_r} + {1'b0, item_r.slot_count};
  assign t_start  = {1'b0, pc_eff} + {1'b0, temp_r};
  assign lk_lim   = {1'b0, pc_eff} + {1'b0, tc_eff};

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pc_r  <= CNT_W'(1024);
      cfg_tc_r  <= CNT_W'(1024);
      cfg_dsz_r <= DSZ_W'(32);
      cfg_sv_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PERSISTENT: cfg_pc_r  <= cfg_data;
        CFG_TEMPORARY:  cfg_tc_r  <= cfg_data;
        CFG_DESC_SIZE:  cfg_dsz_r <= cfg_data[DSZ_W-1:0];
        CFG_SHADER_VIS: cfg_sv_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Free-index stack; it is always read at the current allocation count.
  dsa_stack #(
    .MAX_PERSISTENT (MAX_PERSISTENT)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr_i (IDX_W'(alloc_r)),
    .rd_data_o (stk_rd_data),
    .wr_i      (stk_wr)
  );

  // Sequencer: next state, request decode and counter updates.
  always_comb begin
    state_nxt = state_r;
    alloc_nxt = alloc_r;
    temp_nxt  = temp_r;
    heap_nxt  = heap_r;
    res       = NO_SLOT;
    status    = ST_OK;
    stk_wr    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (item_r.opcode)
          OP_ALLOC_P: begin
            if (alloc_r >= pc_eff) begin
              status = ST_PFULL;
            end else begin
              res       = stk_rd_data;
              alloc_nxt = alloc_r + CNT_W'(1);
            end
          end
          OP_FREE_P: begin
            if (item_r.slot_index != NO_SLOT) begin
              if ((item_r.slot_index >= {1'b0, pc_eff}) || (alloc_r == '0)) begin
                status = ST_BADFREE;
              end else begin
                stk_wr.en   = 1'b1;
                stk_wr.addr = IDX_W'(alloc_r - CNT_W'(1));
                stk_wr.data = item_r.slot_index;
                alloc_nxt   = alloc_r - CNT_W'(1);
              end
            end
          end
          OP_ALLOC_T: begin
            if ((item_r.slot_count == '0) || (t_sum > {1'b0, tc_eff})) begin
              status = ST_TOVER;
            end else begin
              res      = t_start;
              temp_nxt = t_sum[CNT_W-1:0];
            end
          end
          OP_END_FRAME: begin
            temp_nxt = '0;
            if (!cfg_sv_r || (heap_inc == 3'(FRAMES))) begin
              heap_nxt = '0;
            end else begin
              heap_nxt = heap_inc[HEAP_W-1:0];
            end
          end
          OP_LOOKUP: begin
            if (({1'b0, item_r.frame_select} >= heap_cnt) ||
                (item_r.slot_index >= lk_lim)) begin
              status = ST_BADLOOK;
            end else begin
              res = item_r.slot_index;
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Byte offset of the result index.
  assign prod = (IDX_W+DSZ_W)'(res) * (IDX_W+DSZ_W)'(cfg_dsz_r);

  always_comb begin
    out_nxt.result_index = res;
    out_nxt.byte_offset  = (res == NO_SLOT) ? '0 : prod[OFS_W-1:0];
    out_nxt.heap_slot    = heap_nxt;
    out_nxt.in_use_count = alloc_nxt;
    out_nxt.status       = status;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      alloc_r      <= '0;
      temp_r       <= '0;
      heap_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      alloc_r      <= alloc_nxt;
      temp_r       <= temp_nxt;
      heap_r       <= heap_nxt;
      out_strobe_r <= (state_r == S_EXEC);
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (state_r == S_EXEC) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  `DSA_ASSERT(a_exec_strobes, (state_r == S_EXEC) |=> out_strobe_r, "result strobe missing")
  `DSA_ASSERT(a_idle_quiet, (state_r == S_IDLE) |=> !out_strobe_r, "result strobe without request")
  `DSA_ASSERT(a_in_use_range, LIM_W'(alloc_r) <= LIM_W'(MAX_PERSISTENT), "in-use count overflow")
  `DSA_ASSERT(a_heap_range, 3'(heap_r) < 3'(FRAMES), "heap slot out of range")
  `DSA_ASSERT_RST(a_reset_idle, !rst_n |=> !busy && !out_strobe_r, "reset left block active")

endmodule
